// File: sv/kms_pkg.sv
// shared types, codes and helpers of the key macro sequencer
`timescale 1ns / 1ps

package kms_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int MAX_RESULTS         = 32;
   localparam int RES_W               = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IDX_W           = 2;

   // input word kinds
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_TAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_WAIT = 2'd2;

   // table entry codes
   localparam logic [3:0] ET_ACTION    = 4'd0;
   localparam logic [3:0] ET_TAP       = 4'd1;
   localparam logic [3:0] ET_PRESS     = 4'd2;
   localparam logic [3:0] ET_RELEASE   = 4'd3;
   localparam logic [3:0] ET_TAP_TIME  = 4'd4;
   localparam logic [3:0] ET_WAIT_TIME = 4'd5;
   localparam logic [3:0] ET_PAUSE     = 4'd6;
   localparam logic [3:0] ET_ROUTE_11  = 4'd7;
   localparam logic [3:0] ET_ROUTE_12  = 4'd8;
   localparam logic [3:0] ET_ROUTE_21  = 4'd9;
   localparam logic [3:0] ET_ROUTE_22  = 4'd10;

   typedef enum logic [1:0] {
      MODE_TAP     = 2'd0,
      MODE_PRESS   = 2'd1,
      MODE_RELEASE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SRC_ENTRY  = 2'd0,
      SRC_MACRO1 = 2'd1,
      SRC_MACRO2 = 2'd2
   } src_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  entry_index;
      logic [3:0]  entry_type;
      logic [7:0]  entry_action;
      logic [31:0] entry_first_param;
      logic [31:0] entry_second_param;
      logic [31:0] macro_first_param;
      logic [31:0] macro_second_param;
   } req_type;

   typedef struct packed {
      logic [7:0]  action_id;
      logic [31:0] action_first_param;
      logic [31:0] action_second_param;
      logic        is_press;
      logic [31:0] delay_ms;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  etype;
      logic [7:0]  action;
      logic [31:0] p1;
      logic [31:0] p2;
   } tbl_entry_type;

   typedef struct packed {
      logic wr_entry;
      logic start_press;
      logic start_release;
      logic rd_en;
      logic apply_ctrl;
      logic clear_src;
      logic latch_action;
      logic idx_inc;
      logic push;
      logic second;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic idx_done;
      logic is_ctrl;
      logic at_pause;
      logic mode_tap;
      logic hold_valid;
      logic out_free;
      logic count_last;
   } status_type;

   function automatic logic [31:0] pick(src_type s, logic [31:0] own,
                                        logic [31:0] m1, logic [31:0] m2);
      logic [31:0] r;
      unique case (s)
         SRC_MACRO1: r = m1;
         SRC_MACRO2: r = m2;
         default:    r = own;
      endcase
      return r;
   endfunction

endpackage

// File: sv/kms_datapath.sv
// macro table, walk state, event hold stage and output register
`timescale 1ns / 1ps

module kms_datapath #(
   parameter int MAX_ENTRIES = kms_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kms_pkg::req_type               req_data,
   input  logic                           csr_valid,
   input  logic [kms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data,
   input  kms_pkg::cmd_type               cmd,
   output kms_pkg::status_type            status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output kms_pkg::rsp_type               rsp_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   kms_pkg::tbl_entry_type mem [MAX_ENTRIES];
   kms_pkg::tbl_entry_type rd_ff;

   logic [4:0]  entry_count_ff, entry_count_in;
   logic [31:0] tap_def_ff, tap_def_in;
   logic [31:0] wait_def_ff, wait_def_in;

   logic [CNT_W-1:0]        idx_ff, idx_in;
   kms_pkg::mode_type       mode_ff, mode_in;
   logic [31:0]             tap_ff, tap_in;
   logic [31:0]             wait_ff, wait_in;
   kms_pkg::src_type        src1_ff, src1_in;
   kms_pkg::src_type        src2_ff, src2_in;
   logic [31:0]             m1_ff, m1_in;
   logic [31:0]             m2_ff, m2_in;
   logic [7:0]              act_id_ff, act_id_in;
   logic [31:0]             act_p1_ff, act_p1_in;
   logic [31:0]             act_p2_ff, act_p2_in;
   logic [kms_pkg::RES_W-1:0] res_cnt_ff, res_cnt_in;
   logic                    hold_valid_ff, hold_valid_in;
   kms_pkg::rsp_type        hold_ff, hold_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   kms_pkg::rsp_type        rsp_ff, rsp_in;

   logic [CNT_W-1:0]  used;
   logic [IDX_W+3:0]  wr_wide;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_ok;
   logic              is_ctrl;
   kms_pkg::rsp_type  ev;

   assign wr_wide = {{IDX_W{1'b0}}, req_data.entry_index};
   assign wr_addr = wr_wide[IDX_W-1:0];
   assign wr_ok   = 32'(req_data.entry_index) < 32'(MAX_ENTRIES);

   always_comb begin
      if (32'(entry_count_ff) > 32'(MAX_ENTRIES)) begin
         used = CNT_W'(MAX_ENTRIES);
      end else begin
         used = CNT_W'(entry_count_ff);
      end
   end

   always_comb begin
      unique case (rd_ff.etype) inside
         kms_pkg::ET_TAP, kms_pkg::ET_PRESS, kms_pkg::ET_RELEASE,
         kms_pkg::ET_TAP_TIME, kms_pkg::ET_WAIT_TIME,
         kms_pkg::ET_ROUTE_11, kms_pkg::ET_ROUTE_12,
         kms_pkg::ET_ROUTE_21, kms_pkg::ET_ROUTE_22: is_ctrl = 1'b1;
         default: is_ctrl = 1'b0;
      endcase
   end

   // event built from the latched action and the current mode, or the release half of a tap when second is set
   always_comb begin
      ev.action_id           = act_id_ff;
      ev.action_first_param  = act_p1_ff;
      ev.action_second_param = act_p2_ff;
      ev.last                = 1'b0;
      if (cmd.second) begin
         ev.is_press = 1'b0;
         ev.delay_ms = wait_ff;
      end else begin
         ev.is_press = (mode_ff != kms_pkg::MODE_RELEASE);
         ev.delay_ms = (mode_ff == kms_pkg::MODE_TAP) ? tap_ff : wait_ff;
      end
   end

   always_comb begin
      entry_count_in = entry_count_ff;
      tap_def_in     = tap_def_ff;
      wait_def_in    = wait_def_ff;
      idx_in         = idx_ff;
      mode_in        = mode_ff;
      tap_in         = tap_ff;
      wait_in        = wait_ff;
      src1_in        = src1_ff;
      src2_in        = src2_ff;
      m1_in          = m1_ff;
      m2_in          = m2_ff;
      act_id_in      = act_id_ff;
      act_p1_in      = act_p1_ff;
      act_p2_in      = act_p2_ff;
      res_cnt_in     = res_cnt_ff;
      hold_valid_in  = hold_valid_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      if (csr_valid) begin
         unique case (csr_index)
            kms_pkg::CSR_ENTRY_COUNT:  entry_count_in = csr_data[4:0];
            kms_pkg::CSR_DEFAULT_TAP:  tap_def_in     = csr_data;
            kms_pkg::CSR_DEFAULT_WAIT: wait_def_in    = csr_data;
            default: ;
         endcase
      end

      if (cmd.start_press || cmd.start_release) begin
         idx_in     = '0;
         mode_in    = kms_pkg::MODE_TAP;
         src1_in    = kms_pkg::SRC_ENTRY;
         src2_in    = kms_pkg::SRC_ENTRY;
         m1_in      = req_data.macro_first_param;
         m2_in      = req_data.macro_second_param;
         res_cnt_in = '0;
         tap_in     = cmd.start_press ? tap_def_ff : 32'd0;
         wait_in    = cmd.start_press ? wait_def_ff : 32'd0;
      end

      if (cmd.apply_ctrl) begin
         unique case (rd_ff.etype)
            kms_pkg::ET_TAP:       mode_in = kms_pkg::MODE_TAP;
            kms_pkg::ET_PRESS:     mode_in = kms_pkg::MODE_PRESS;
            kms_pkg::ET_RELEASE:   mode_in = kms_pkg::MODE_RELEASE;
            kms_pkg::ET_TAP_TIME:  tap_in  = rd_ff.p1;
            kms_pkg::ET_WAIT_TIME: wait_in = rd_ff.p1;
            kms_pkg::ET_ROUTE_11:  src1_in = kms_pkg::SRC_MACRO1;
            kms_pkg::ET_ROUTE_12:  src2_in = kms_pkg::SRC_MACRO1;
            kms_pkg::ET_ROUTE_21:  src1_in = kms_pkg::SRC_MACRO2;
            kms_pkg::ET_ROUTE_22:  src2_in = kms_pkg::SRC_MACRO2;
            default: ;
         endcase
      end

      if (cmd.latch_action) begin
         act_id_in = rd_ff.action;
         act_p1_in = kms_pkg::pick(src1_ff, rd_ff.p1, m1_ff, m2_ff);
         act_p2_in = kms_pkg::pick(src2_ff, rd_ff.p2, m1_ff, m2_ff);
      end
      if (cmd.latch_action || cmd.clear_src) begin
         src1_in = kms_pkg::SRC_ENTRY;
         src2_in = kms_pkg::SRC_ENTRY;
      end

      if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // one word waits in hold so the final one can be flagged
      if (cmd.push) begin
         if (hold_valid_ff) begin
            rsp_in       = hold_ff;
            rsp_valid_in = 1'b1;
         end
         hold_in       = ev;
         hold_valid_in = 1'b1;
         res_cnt_in    = res_cnt_ff + kms_pkg::RES_W'(1);
      end else if (cmd.flush) begin
         rsp_in        = hold_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_entry && wr_ok) begin
         mem[wr_addr] <= '{etype:  req_data.entry_type,
                           action: req_data.entry_action,
                           p1:     req_data.entry_first_param,
                           p2:     req_data.entry_second_param};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         tap_def_ff     <= '0;
         wait_def_ff    <= '0;
         idx_ff         <= '0;
         res_cnt_ff     <= '0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         tap_def_ff     <= tap_def_in;
         wait_def_ff    <= wait_def_in;
         idx_ff         <= idx_in;
         res_cnt_ff     <= res_cnt_in;
         hold_valid_ff  <= hold_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      tap_ff    <= tap_in;
      wait_ff   <= wait_in;
      src1_ff   <= src1_in;
      src2_ff   <= src2_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      act_id_ff <= act_id_in;
      act_p1_ff <= act_p1_in;
      act_p2_ff <= act_p2_in;
      hold_ff   <= hold_in;
      rsp_ff    <= rsp_in;
   end

   assign status.idx_done   = (idx_ff >= used);
   assign status.is_ctrl    = is_ctrl;
   assign status.at_pause   = (rd_ff.etype == kms_pkg::ET_PAUSE);
   assign status.mode_tap   = (mode_ff == kms_pkg::MODE_TAP);
   assign status.hold_valid = hold_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.count_last = (res_cnt_ff == kms_pkg::RES_W'(kms_pkg::MAX_RESULTS - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/kms_ctrl.sv
// sequencer state machine that walks the macro table
`timescale 1ns / 1ps

module kms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   output logic                 req_ready,
   input  kms_pkg::status_type  status,
   output kms_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_EXEC   = 6'b000100,
      S_EMIT1  = 6'b001000,
      S_EMIT2  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      PH_PRESS = 2'd0,
      PH_SCAN  = 2'd1,
      PH_WALK  = 2'd2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      can_push;

   assign req_ready = (state_ff == S_IDLE);
   assign can_push  = !status.hold_valid || status.out_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  kms_pkg::KIND_WRITE: cmd.wr_entry = 1'b1;
                  kms_pkg::KIND_PRESS: begin
                     cmd.start_press = 1'b1;
                     phase_in        = PH_PRESS;
                     state_in        = S_READ;
                  end
                  kms_pkg::KIND_RELEASE: begin
                     cmd.start_release = 1'b1;
                     phase_in          = PH_SCAN;
                     state_in          = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            if (status.idx_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.is_ctrl) begin
               cmd.apply_ctrl = 1'b1;
               cmd.idx_inc    = 1'b1;
               state_in       = S_READ;
            end else if (status.at_pause) begin
               if (phase_ff == PH_PRESS) begin
                  state_in = S_FINISH;
               end else begin
                  // the first pause on release starts the emitting walk
                  phase_in    = PH_WALK;
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end else if (phase_ff == PH_SCAN) begin
               cmd.clear_src = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_READ;
            end else begin
               cmd.latch_action = 1'b1;
               state_in         = S_EMIT1;
            end
         end
         S_EMIT1: begin
            if (can_push) begin
               cmd.push = 1'b1;
               if (status.count_last) begin
                  state_in = S_FINISH;
               end else if (status.mode_tap) begin
                  state_in = S_EMIT2;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_EMIT2: begin
            if (can_push) begin
               cmd.push   = 1'b1;
               cmd.second = 1'b1;
               if (status.count_last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_FINISH: begin
            if (!status.hold_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_PRESS;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: sv/key_macro_sequencer_top.sv
// key macro sequencer top level: controller, datapath and checks
`timescale 1ns / 1ps

// Usage:
// req_* carries one word: a table write, a macro key press or a key release.
// csr_* writes the entry count (0), the default tap time (1) and the default
// wait time (2); it is always ready and must be written only while the block is
// idle, which the block itself does not enforce. rsp_* carries the key events a
// trigger causes, the final one with last set. A table write leaves the block
// ready again at once. A trigger walks the table one entry at a time through a
// registered read: each entry is read, then executed; a press or release action
// then emits its event, a tap action emits a press and then a release event, and
// a finish step flushes the last event. The first event shows up one event
// behind the walk, since each event waits in a hold stage until the next one is
// known. Events leave through an output register; when the receiver stalls, the
// walk stops at the next event until a slot frees up. req_ready is high only
// between triggers. Synchronous reset clears the counters, the configuration
// registers and the valid flags, sets the state machine to idle and drops
// rsp_valid; the table contents are undefined until written.

module key_macro_sequencer_top #(
   parameter int MAX_ENTRIES = kms_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  kms_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output kms_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);

   kms_pkg::cmd_type    cmd;
   kms_pkg::status_type status;

   assign csr_ready = 1'b1;

   kms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kms_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // nothing may wait in the hold stage between triggers
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.hold_valid)
      else $error("event left in hold stage while idle");

   // a push never overwrites the output register while it is stalled
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!status.hold_valid || status.out_free))
      else $error("event pushed without room");

   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (status.hold_valid && status.out_free))
      else $error("final event flushed without data or room");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed");

endmodule
